FILE: sv/amls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amls_pkg
// Shared constants and types of the adaptive min/max level slicer.
// ----------------------------------------------------------------------------
package amls_pkg;

    localparam int WINDOW_LEN_DEF  = 256;
    localparam int SAMPLE_BITS_DEF = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD_RD,
        ST_HEAD_CHK,
        ST_BACK_RD,
        ST_BACK_CHK,
        ST_PUSH,
        ST_FRONT,
        ST_OUT
    } t_state;

    // queue select
    localparam logic Q_LOW  = 1'b0;
    localparam logic Q_HIGH = 1'b1;

endpackage

FILE: sv/amls_sample_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amls_sample_if
// Valid/ready channel carrying one signed sample per beat.
// ----------------------------------------------------------------------------
interface amls_sample_if #(
    parameter int SAMPLE_BITS = amls_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

FILE: sv/amls_level_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amls_level_if
// Valid/ready channel carrying one logic level per beat.
// ----------------------------------------------------------------------------
interface amls_level_if;
    logic valid;
    logic ready;
    logic level;

    modport source (output valid, output level, input ready);
    modport sink   (input valid, input level, output ready);
endinterface

FILE: sv/adaptive_minmax_level_slicer.sv
`timescale 1ns / 1ps
// One sample in flight: the input is ready only in the idle state, so a new sample is
// taken only once the last one has reached the output register. An empty queue skips
// the head and back checks. Each sample is dropped at most once per queue, so the back
// drops per sample average at most two over both queues. The state sequence is set by
// the single read port of each queue RAM. The next sample is accepted while a result
// waits in the output register.
// Reset (sync, active low) empties both queues and zeroes the frame counter.
// ----------------------------------------------------------------------------
// adaptive_minmax_level_slicer
// Slices samples against the midpoint of the running min/max over a sliding
// window, using two monotonic queues kept in RAM.
// ----------------------------------------------------------------------------
module adaptive_minmax_level_slicer #(
    parameter int WINDOW_LEN  = amls_pkg::WINDOW_LEN_DEF,
    parameter int SAMPLE_BITS = amls_pkg::SAMPLE_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    amls_sample_if.sink    i_in,
    amls_level_if.source   o_out
);

    localparam int PTR_MOD = 2 * WINDOW_LEN;
    localparam int PTR_W   = $clog2(PTR_MOD);
    localparam int IDX_W   = $clog2(WINDOW_LEN);
    localparam int ENT_W   = PTR_W + SAMPLE_BITS;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(PTR_MOD - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(PTR_MOD - 1) : p - 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] ptr_idx(input logic [PTR_W-1:0] p);
        return (p >= PTR_W'(WINDOW_LEN)) ? IDX_W'(p - PTR_W'(WINDOW_LEN)) : IDX_W'(p);
    endfunction

    amls_pkg::t_state              r_state, n_state;
    logic                          r_sel, n_sel;
    logic [PTR_W-1:0]              r_head [2];
    logic [PTR_W-1:0]              r_tail [2];
    logic [PTR_W-1:0]              n_head [2];
    logic [PTR_W-1:0]              n_tail [2];
    logic [PTR_W-1:0]              r_frame, n_frame;
    logic                          r_out_valid, n_out_valid;
    logic                          r_out_level, n_out_level;
    logic signed [SAMPLE_BITS-1:0] r_sample, n_sample;
    logic signed [SAMPLE_BITS-1:0] r_min, n_min;
    logic signed [SAMPLE_BITS-1:0] r_max, n_max;
    logic                          r_push_empty, n_push_empty;

    logic                          ram_we;
    logic [IDX_W-1:0]              ram_waddr;
    logic [IDX_W-1:0]              ram_raddr;
    logic [ENT_W-1:0]              ram_wdata;
    logic [ENT_W-1:0]              low_rdata;
    logic [ENT_W-1:0]              high_rdata;
    logic [ENT_W-1:0]              rdata;

    logic [PTR_W-1:0]              cur_head;
    logic [PTR_W-1:0]              cur_tail;
    logic                          cur_empty;
    logic [PTR_W-1:0]              rd_frame;
    logic signed [SAMPLE_BITS-1:0] rd_value;
    logic [PTR_W:0]                age;
    logic                          expired;
    logic                          drop;
    logic signed [SAMPLE_BITS:0]   mid_sum;
    logic signed [SAMPLE_BITS:0]   threshold;

    amls_ram #(.WIDTH(ENT_W), .DEPTH(WINDOW_LEN)) u_low_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we && (r_sel == amls_pkg::Q_LOW)),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (low_rdata)
    );

    amls_ram #(.WIDTH(ENT_W), .DEPTH(WINDOW_LEN)) u_high_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we && (r_sel == amls_pkg::Q_HIGH)),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (high_rdata)
    );

    assign rdata     = (r_sel == amls_pkg::Q_HIGH) ? high_rdata : low_rdata;
    assign rd_frame  = rdata[ENT_W-1:SAMPLE_BITS];
    assign rd_value  = rdata[SAMPLE_BITS-1:0];
    assign cur_head  = r_head[r_sel];
    assign cur_tail  = r_tail[r_sel];
    assign cur_empty = (cur_head == cur_tail);

    // frame age modulo 2*WINDOW_LEN
    assign age = (r_frame >= rd_frame)
               ? {1'b0, r_frame} - {1'b0, rd_frame}
               : {1'b0, r_frame} + (PTR_W+1)'(PTR_MOD) - {1'b0, rd_frame};
    assign expired = (age >= (PTR_W+1)'(WINDOW_LEN));

    assign drop = (r_sel == amls_pkg::Q_LOW) ? (rd_value >= r_sample)
                                             : (rd_value <= r_sample);

    // midpoint, halving truncated toward zero
    assign mid_sum   = (SAMPLE_BITS+1)'(r_min) + (SAMPLE_BITS+1)'(r_max);
    assign threshold = (mid_sum + $signed({{SAMPLE_BITS{1'b0}}, mid_sum[SAMPLE_BITS]})) >>> 1;

    assign i_in.ready  = (r_state == amls_pkg::ST_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.level = r_out_level;

    always_comb begin
        n_state      = r_state;
        n_sel        = r_sel;
        n_head       = r_head;
        n_tail       = r_tail;
        n_frame      = r_frame;
        n_sample     = r_sample;
        n_min        = r_min;
        n_max        = r_max;
        n_push_empty = r_push_empty;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_level  = r_out_level;
        ram_we       = 1'b0;
        ram_waddr    = ptr_idx(cur_tail);
        ram_wdata    = {r_frame, r_sample};
        ram_raddr    = ptr_idx(cur_head);

        case (r_state)
            amls_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_sample = i_in.sample;
                    n_sel    = amls_pkg::Q_LOW;
                    n_state  = amls_pkg::ST_HEAD_RD;
                end
            end
            amls_pkg::ST_HEAD_RD: begin
                // at most one entry can age out per sample
                n_state = cur_empty ? amls_pkg::ST_BACK_RD : amls_pkg::ST_HEAD_CHK;
            end
            amls_pkg::ST_HEAD_CHK: begin
                if (expired) begin
                    n_head[r_sel] = ptr_inc(cur_head);
                end
                n_state = amls_pkg::ST_BACK_RD;
            end
            amls_pkg::ST_BACK_RD: begin
                ram_raddr = ptr_idx(ptr_dec(cur_tail));
                n_state   = cur_empty ? amls_pkg::ST_PUSH : amls_pkg::ST_BACK_CHK;
            end
            amls_pkg::ST_BACK_CHK: begin
                if (drop) begin
                    n_tail[r_sel] = ptr_dec(cur_tail);
                    n_state       = amls_pkg::ST_BACK_RD;
                end else begin
                    n_state = amls_pkg::ST_PUSH;
                end
            end
            amls_pkg::ST_PUSH: begin
                // head read here; when empty it collides with the write, use the sample
                ram_we        = 1'b1;
                n_tail[r_sel] = ptr_inc(cur_tail);
                n_push_empty  = cur_empty;
                n_state       = amls_pkg::ST_FRONT;
            end
            amls_pkg::ST_FRONT: begin
                if (r_sel == amls_pkg::Q_LOW) begin
                    n_min   = r_push_empty ? r_sample : rd_value;
                    n_sel   = amls_pkg::Q_HIGH;
                    n_state = amls_pkg::ST_HEAD_RD;
                end else begin
                    n_max   = r_push_empty ? r_sample : rd_value;
                    n_state = amls_pkg::ST_OUT;
                end
            end
            amls_pkg::ST_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_level = ((SAMPLE_BITS+1)'(r_sample) > threshold);
                    n_frame     = ptr_inc(r_frame);
                    n_state     = amls_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = amls_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= amls_pkg::ST_IDLE;
            r_sel       <= amls_pkg::Q_LOW;
            r_head[0]   <= '0;
            r_head[1]   <= '0;
            r_tail[0]   <= '0;
            r_tail[1]   <= '0;
            r_frame     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sel       <= n_sel;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_frame     <= n_frame;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample     <= n_sample;
        r_min        <= n_min;
        r_max        <= n_max;
        r_push_empty <= n_push_empty;
        r_out_level  <= n_out_level;
    end

endmodule

FILE: sv/amls_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amls_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module amls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
